/* rtl/stc_pkg.sv */
// Shared types and constants for the slot table with compaction.
// Used by the cell, controller, top level and checker; depends on nothing.
`default_nettype none

package stc_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int CNT_W       = $clog2(TABLE_DEPTH);
	localparam int KIND_W      = 8;
	localparam int BODY_W      = 56;
	localparam int IDX_W       = 8;
	localparam int CNT8_W      = 8;

	localparam logic [KIND_W-1:0] RESET_MARKER = 8'd30;

	localparam logic [2:0] MODE_INSERT  = 3'd0;
	localparam logic [2:0] MODE_REMOVE  = 3'd1;
	localparam logic [2:0] MODE_READ    = 3'd2;
	localparam logic [2:0] MODE_COMPACT = 3'd3;
	localparam logic [2:0] MODE_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [BODY_W-1:0] body;
		logic [KIND_W-1:0] kind;
	} record_t;

	typedef struct packed {
		logic [BODY_W-1:0] entry_body;
		logic [KIND_W-1:0] entry_kind;
		logic [IDX_W-1:0]  slot_index;
		logic [2:0]        mode;
	} req_t;

	typedef struct packed {
		logic [CNT8_W-1:0] free_count;
		logic [CNT8_W-1:0] used_count;
		logic [BODY_W-1:0] read_body;
		logic [KIND_W-1:0] read_kind;
		logic [IDX_W-1:0]  result_index;
		logic [1:0]        status;
	} rsp_t;

	localparam int IN_W        = $bits(req_t);
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = $bits(rsp_t);
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic              shift;
		logic              compact;
		logic              phase;
		logic [KIND_W-1:0] marker;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/stc_cell.sv */
// One slot of the table: a record register that shifts toward the head or
// swaps with its neighbor during compaction. Depends on stc_pkg.
`default_nettype none

module stc_cell
	import stc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_cmd_t         cmd,
	input  wire logic              left_member,
	input  wire logic              right_member,
	input  wire record_t           nbr_in,
	input  wire logic [KIND_W-1:0] left_kind,
	output record_t                rec
);

	record_t rec_q;
	record_t rec_d;
	record_t clean;
	logic    self_empty;
	logic    nbr_used;
	logic    left_empty;

	assign clean      = '{body: '0, kind: cmd.marker};
	assign self_empty = (rec_q.kind == cmd.marker);
	assign nbr_used   = (nbr_in.kind != cmd.marker);
	assign left_empty = (left_kind == cmd.marker);

	// During compaction a used record moves one place toward the head when the
	// slot in front of it is empty, so used records keep their order.
	always_comb begin
		rec_d = rec_q;
		if (cmd.shift) begin
			rec_d = nbr_in;
		end else if (cmd.compact) begin
			if (left_member && self_empty && nbr_used) begin
				rec_d = nbr_in;
			end else if (right_member && left_empty && !self_empty) begin
				rec_d = clean;
			end else if (self_empty) begin
				rec_d = clean;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '{body: '0, kind: RESET_MARKER};
		end else begin
			rec_q <= rec_d;
		end
	end

	assign rec = rec_q;

endmodule

`default_nettype wire

/* rtl/stc_ctrl.sv */
// Sequencer, head processing, counters, marker register and output register.
// Rotates the cell chain once per request. Depends on stc_pkg.
`default_nettype none

module stc_ctrl
	import stc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp,
	input  wire logic              cfg_valid,
	input  wire logic [KIND_W-1:0] cfg_data,
	input  wire record_t           head,
	output record_t                tail,
	output cell_cmd_t              cmd
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_COMPACT = 2'd1;
	localparam logic [1:0] S_ROTATE  = 2'd2;
	localparam logic [1:0] S_FINISH  = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2:0]        mode_q;
	logic [IDX_W-1:0]  idx_q;
	record_t           new_q;
	logic              found_q;
	logic [IDX_W-1:0]  res_idx_q;
	record_t           rd_q;
	logic [CNT8_W-1:0] used_q;
	logic [KIND_W-1:0] marker_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              cnt_last;
	logic              idx_hit;
	logic              in_range;
	logic              take_new;
	logic [CNT8_W-1:0] used_nxt;
	record_t           clean;
	rsp_t              rsp_d;
	logic              out_free;

	assign clean    = '{body: '0, kind: marker_q};
	assign cnt_last = (cnt_q == CNT_W'(TABLE_DEPTH - 1));
	assign idx_hit  = ({{(IDX_W - CNT_W){1'b0}}, cnt_q} == idx_q);
	assign in_range = ({1'b0, idx_q} < 9'(TABLE_DEPTH));
	assign take_new = (mode_q == MODE_INSERT) && !found_q && (head.kind == marker_q);

	// The record at the head is slot cnt_q; its processed form enters the tail
	// and lands back in slot cnt_q after the full rotation.
	always_comb begin
		tail = head;
		unique case (mode_q)
			MODE_INSERT: begin
				if (take_new) begin
					tail = new_q;
				end
			end
			MODE_REMOVE: begin
				if (idx_hit) begin
					tail = clean;
				end
			end
			MODE_CLEAR: begin
				tail = clean;
			end
			default: begin
				tail = head;
			end
		endcase
	end

	assign used_nxt = used_q + CNT8_W'(tail.kind != marker_q);

	always_comb begin
		rsp_d              = '0;
		rsp_d.used_count   = used_q;
		rsp_d.free_count   = CNT8_W'(TABLE_DEPTH) - used_q;
		rsp_d.result_index = found_q ? res_idx_q : '0;
		unique case (mode_q)
			MODE_INSERT: begin
				rsp_d.status = found_q ? ST_OK : ST_FULL;
			end
			MODE_REMOVE: begin
				rsp_d.status = in_range ? ST_OK : ST_RANGE;
			end
			MODE_READ: begin
				rsp_d.status    = in_range ? ST_OK : ST_RANGE;
				rsp_d.read_kind = in_range ? rd_q.kind : marker_q;
				rsp_d.read_body = in_range ? rd_q.body : '0;
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			mode_q      <= MODE_INSERT;
			idx_q       <= '0;
			new_q       <= '0;
			found_q     <= 1'b0;
			res_idx_q   <= '0;
			rd_q        <= '0;
			used_q      <= '0;
			marker_q    <= RESET_MARKER;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				marker_q <= cfg_data;
			end
			// A new result may replace one that is taken in the same cycle.
			if (state_q == S_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q  <= req.mode;
						idx_q   <= req.slot_index;
						new_q   <= '{body: req.entry_body, kind: req.entry_kind};
						found_q <= 1'b0;
						rd_q    <= '0;
						used_q  <= '0;
						cnt_q   <= '0;
						state_q <= (req.mode == MODE_COMPACT) ? S_COMPACT : S_ROTATE;
					end
				end
				S_COMPACT: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= S_ROTATE;
					end
				end
				S_ROTATE: begin
					used_q <= used_nxt;
					if (take_new) begin
						found_q   <= 1'b1;
						res_idx_q <= IDX_W'(cnt_q);
					end
					if (mode_q == MODE_READ && idx_hit) begin
						rd_q <= head;
					end
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						rsp_q   <= rsp_d;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;
	assign cmd.shift   = (state_q == S_ROTATE);
	assign cmd.compact = (state_q == S_COMPACT);
	assign cmd.phase   = cnt_q[0];
	assign cmd.marker  = marker_q;

endmodule

`default_nettype wire

/* rtl/slot_table_with_compaction_top.sv */
// One request at a time: the next is taken only after the result of the previous
// is registered, which takes one full rotation of the cell chain (plus one
// odd-even swap sweep for compact), and longer while a previous result still
// waits. Reset: asynchronous, active low; every slot empty with marker 30, body
// zero.
`default_nettype none

module slot_table_with_compaction_top
	import stc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// mode[2:0], slot_index[10:3], entry_kind[18:11], entry_body[74:19], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// status[1:0], result_index[9:2], read_kind[17:10], read_body[73:18],
	// used_count[81:74], free_count[89:82], zero pad
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [KIND_W-1:0]      cfg_data
);

	req_t      req;
	rsp_t      rsp;
	record_t   tail;
	cell_cmd_t cmd;
	record_t   rec [TABLE_DEPTH];

	assign req       = s_tdata[IN_W-1:0];
	assign m_tdata   = {{(OUT_TDATA_W - OUT_W){1'b0}}, rsp};
	assign cfg_ready = 1'b1;

	stc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.rsp_valid (m_tvalid),
		.rsp_ready (m_tready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.head      (rec[0]),
		.tail      (tail),
		.cmd       (cmd)
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		record_t           nbr;
		logic [KIND_W-1:0] lkind;
		logic              lm;
		logic              rm;

		if (i < TABLE_DEPTH - 1) begin : g_mid
			assign nbr = rec[i+1];
			assign lm  = (cmd.phase == 1'((i % 2) != 0));
		end else begin : g_last
			assign nbr = tail;
			assign lm  = 1'b0;
		end

		if (i > 0) begin : g_left
			assign lkind = rec[i-1].kind;
			assign rm    = (cmd.phase == 1'(((i - 1) % 2) != 0));
		end else begin : g_first
			assign lkind = cmd.marker;
			assign rm    = 1'b0;
		end

		stc_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.left_member  (lm),
			.right_member (rm),
			.nbr_in       (nbr),
			.left_kind    (lkind),
			.rec          (rec[i])
		);
	end

endmodule

`default_nettype wire

/* rtl/stc_checker.sv */
// Port-level checks for the slot table, bound to the top level.
// Depends on stc_pkg.
`default_nettype none

module stc_checker
	import stc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [8:0] count_sum;

	assign count_sum = {1'b0, m_tdata[81:74]} + {1'b0, m_tdata[89:82]};

	// A stalled result must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Used and free counts always add up to the table depth.
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> count_sum == 9'(TABLE_DEPTH))
		else $error("used and free counts do not cover the table");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	// A full report means no free slot and no index.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[89:82] == 8'd0
			&& m_tdata[9:2] == 8'd0)
		else $error("table full reported with free slots");

	// The block works on one request at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind slot_table_with_compaction_top stc_checker u_stc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/tb_slot_table_with_compaction_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for slot_table_with_compaction_top: queued requests and
// marker writes go in, every response is checked against a behavioral table model.
// Depends on stc_pkg and the top level only.

module tb_slot_table_with_compaction_top;
	import stc_pkg::*;

	localparam int LIMIT_CYCLES = 2_500_000;
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;
	localparam int PRINT_CAP    = 40;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [KIND_W-1:0]      cfg_data  = '0;

	slot_table_with_compaction_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the table contents and the marker register.
	logic [KIND_W-1:0] tbl_kind [TABLE_DEPTH];
	logic [BODY_W-1:0] tbl_body [TABLE_DEPTH];
	logic [KIND_W-1:0] tbl_marker;

	req_t        req_backlog[$];
	rsp_t        rsp_due[$];
	req_t        on_bus;
	rsp_t        seen;
	rsp_t        want;
	int          src_gap     = 0;
	int          snk_gap     = 0;
	int unsigned idle_pct    = 0;
	int unsigned bad_count   = 0;
	longint      cycle_count = 0;

	function automatic rsp_t table_apply(req_t rq);
		rsp_t rs;
		bit   placed;
		int   i;
		int   dst;
		int   nfree;
		rs = '0;
		placed = 1'b0;
		case (rq.mode)
			MODE_INSERT: begin
				rs.status = ST_FULL;
				for (i = 0; i < TABLE_DEPTH; i++) begin
					if (!placed && tbl_kind[i] == tbl_marker) begin
						tbl_kind[i] = rq.entry_kind;
						tbl_body[i] = rq.entry_body;
						rs.result_index = IDX_W'(i);
						rs.status = ST_OK;
						placed = 1'b1;
					end
				end
			end
			MODE_REMOVE: begin
				if (rq.slot_index < TABLE_DEPTH) begin
					tbl_kind[rq.slot_index[CNT_W-1:0]] = tbl_marker;
					tbl_body[rq.slot_index[CNT_W-1:0]] = '0;
				end else begin
					rs.status = ST_RANGE;
				end
			end
			MODE_READ: begin
				if (rq.slot_index < TABLE_DEPTH) begin
					rs.read_kind = tbl_kind[rq.slot_index[CNT_W-1:0]];
					rs.read_body = tbl_body[rq.slot_index[CNT_W-1:0]];
				end else begin
					rs.read_kind = tbl_marker;
					rs.status = ST_RANGE;
				end
			end
			MODE_COMPACT: begin
				// Used records slide to the front, keeping their order.
				dst = 0;
				for (i = 0; i < TABLE_DEPTH; i++) begin
					if (tbl_kind[i] != tbl_marker) begin
						tbl_kind[dst] = tbl_kind[i];
						tbl_body[dst] = tbl_body[i];
						dst++;
					end
				end
				for (i = dst; i < TABLE_DEPTH; i++) begin
					tbl_kind[i] = tbl_marker;
					tbl_body[i] = '0;
				end
			end
			MODE_CLEAR: begin
				for (i = 0; i < TABLE_DEPTH; i++) begin
					tbl_kind[i] = tbl_marker;
					tbl_body[i] = '0;
				end
			end
			default: begin
			end
		endcase
		nfree = 0;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			if (tbl_kind[i] == tbl_marker)
				nfree++;
		end
		rs.used_count = CNT8_W'(TABLE_DEPTH - nfree);
		rs.free_count = CNT8_W'(nfree);
		return rs;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] got_v, logic [63:0] due_v);
		if (bad_count < PRINT_CAP)
			$display("mismatch at cycle %0d: %0s got %0h, expected %0h",
				cycle_count, what, got_v, due_v);
		bad_count++;
	endtask

	// Request driver: holds a request until it is taken, inserts idle bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				rsp_due.push_back(table_apply(on_bus));
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (req_backlog.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if ($urandom_range(0, 99) < idle_pct) begin
					src_gap = $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else begin
					on_bus = req_backlog.pop_front();
					s_tdata <= IN_TDATA_W'(on_bus);
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// Response monitor with random back-pressure.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[OUT_W-1:0];
				if (rsp_due.size() == 0) begin
					note_mismatch("response with no request pending", m_tdata[63:0], '0);
				end else begin
					want = rsp_due.pop_front();
					if (seen.status != want.status)
						note_mismatch("status", 64'(seen.status), 64'(want.status));
					if (seen.result_index != want.result_index)
						note_mismatch("result_index", 64'(seen.result_index),
							64'(want.result_index));
					if (seen.read_kind != want.read_kind)
						note_mismatch("read_kind", 64'(seen.read_kind), 64'(want.read_kind));
					if (seen.read_body != want.read_body)
						note_mismatch("read_body", 64'(seen.read_body), 64'(want.read_body));
					if (seen.used_count != want.used_count)
						note_mismatch("used_count", 64'(seen.used_count),
							64'(want.used_count));
					if (seen.free_count != want.free_count)
						note_mismatch("free_count", 64'(seen.free_count),
							64'(want.free_count));
					if (m_tdata[OUT_TDATA_W-1:OUT_W] != '0)
						note_mismatch("tdata padding", 64'(m_tdata[OUT_TDATA_W-1:OUT_W]), '0);
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				snk_gap = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("slot_table_with_compaction_top regression: fail");
			$finish;
		end
	end

	function automatic void push_req(logic [2:0] md, logic [IDX_W-1:0] ix,
		logic [KIND_W-1:0] kd, logic [BODY_W-1:0] bd);
		req_t rq;
		rq.mode = md;
		rq.slot_index = ix;
		rq.entry_kind = kd;
		rq.entry_body = bd;
		req_backlog.push_back(rq);
	endfunction

	// Random requests; a high insert weight drives the table to full.
	function automatic void queue_random(int count, int ins_w, bit allow_clear);
		int                pick;
		logic [2:0]        md;
		logic [IDX_W-1:0]  ix;
		logic [KIND_W-1:0] kd;
		logic [BODY_W-1:0] bd;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < ins_w)
				md = MODE_INSERT;
			else if (pick < 94)
				md = pick[0] ? MODE_REMOVE : MODE_READ;
			else if (pick < 97)
				md = MODE_COMPACT;
			else if (pick < 98)
				md = allow_clear ? MODE_CLEAR : MODE_READ;
			else
				md = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 99) < 88)
				ix = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
			else
				ix = IDX_W'($urandom_range(TABLE_DEPTH, 255));
			pick = $urandom_range(0, 99);
			if (pick < 12)
				kd = tbl_marker;
			else if (pick < 16)
				kd = RESET_MARKER;
			else
				kd = KIND_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 5)
				bd = '0;
			else if (pick < 10)
				bd = '1;
			else
				bd = BODY_W'({$urandom, $urandom});
			push_req(md, ix, kd, bd);
		end
	endfunction

	// Returns once every queued request has been taken and answered.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (req_backlog.size() != 0 || s_tvalid || rsp_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Called only while the block is idle.
	task automatic set_marker(logic [KIND_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tbl_marker = val;
		@(posedge clk);
	endtask

	initial begin
		logic [KIND_W-1:0] mark;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_kind[i] = RESET_MARKER;
			tbl_body[i] = '0;
		end
		tbl_marker = RESET_MARKER;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset marker.
		idle_pct = 20;
		push_req(MODE_READ, 8'd0, 8'd0, '0);
		push_req(MODE_READ, 8'(TABLE_DEPTH - 1), 8'd0, '0);
		push_req(MODE_READ, 8'(TABLE_DEPTH), 8'hff, '1);
		push_req(MODE_READ, 8'hff, 8'd0, '0);
		push_req(MODE_INSERT, 8'd0, 8'd0, '0);
		push_req(MODE_INSERT, 8'hff, 8'hff, '1);
		// A record whose kind is the marker is stored but its slot stays free.
		push_req(MODE_INSERT, 8'd0, RESET_MARKER, 56'h123456789abcde);
		push_req(MODE_READ, 8'd2, 8'd0, '0);
		push_req(MODE_INSERT, 8'd0, 8'ha5, 56'h5a5a5a5a5a5a5a);
		push_req(MODE_READ, 8'd2, 8'd0, '0);
		push_req(MODE_REMOVE, 8'd1, 8'd0, '0);
		push_req(MODE_INSERT, 8'd0, 8'h01, 56'h80000000000001);
		push_req(MODE_REMOVE, 8'(TABLE_DEPTH), 8'd0, '0);
		push_req(MODE_REMOVE, 8'hff, 8'd0, '0);
		push_req(MODE_REMOVE, 8'(TABLE_DEPTH - 1), 8'd0, '0);
		push_req(MODE_REMOVE, 8'd0, 8'd0, '0);
		push_req(MODE_COMPACT, 8'd0, 8'd0, '0);
		push_req(MODE_READ, 8'd0, 8'd0, '0);
		push_req(MODE_READ, 8'd1, 8'd0, '0);
		push_req(3'd5, 8'd0, 8'd0, '0);
		push_req(3'd6, 8'h55, 8'haa, 56'h55aa55aa55aa55);
		push_req(3'd7, 8'hff, 8'hff, '1);
		push_req(MODE_CLEAR, 8'd0, 8'd0, '0);
		push_req(MODE_READ, 8'd0, 8'd0, '0);
		push_req(MODE_COMPACT, 8'd0, 8'd0, '0);
		wait_drained();

		// Random phases, each setting the marker anew; some markers are taken
		// from stored kinds so that used records turn free when the marker moves.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: mark = 8'd0;
				1: mark = 8'hff;
				3: mark = RESET_MARKER;
				4, 6: mark = tbl_kind[$urandom_range(0, TABLE_DEPTH - 1)];
				default: mark = KIND_W'($urandom);
			endcase
			idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 35);
			set_marker(mark);
			queue_random(230, (p % 2 == 1) ? 70 : 45, p % 2 == 0);
			wait_drained();
		end

		// Final stretch at full rate.
		idle_pct = 0;
		set_marker(RESET_MARKER);
		queue_random(150, 55, 1'b1);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_count == 0) begin
			$display("slot_table_with_compaction_top regression: pass");
		end else begin
			$display("slot_table_with_compaction_top regression: fail");
		end
		$finish;
	end

endmodule
